// File: sv/rsh_pkg.sv
package rsh_pkg;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // One root bit per square-root stage, one quotient bit per divide stage.
  localparam int unsigned SQRT_STEPS = 65;
  localparam int unsigned DIV_STEPS  = 17;

  localparam logic [16:0] FRAC_ONE  = 17'h10000;
  localparam logic [16:0] FRAC_ZERO = 17'h00000;

  // Classified test handed from the front end to the back end.
  typedef struct packed {
    logic        origin_in;
    logic        miss;
    logic [64:0] proj;
    logic [63:0] vl2;
    logic [65:0] outside;
  } rsh_item_t;

endpackage

// File: sv/rsh_front.sv
module rsh_front (
  input  logic                signed [31:0] center_x_i,
  input  logic                signed [31:0] center_y_i,
  input  logic                signed [31:0] center_z_i,
  input  logic                       [30:0] sphere_radius_i,
  input  logic                signed [31:0] origin_x_i,
  input  logic                signed [31:0] origin_y_i,
  input  logic                signed [31:0] origin_z_i,
  input  logic                signed [31:0] dir_x_i,
  input  logic                signed [31:0] dir_y_i,
  input  logic                signed [31:0] dir_z_i,
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  output logic                              item_valid_o,
  input  logic                              item_ready_i,
  output rsh_pkg::rsh_item_t                item_o
);
  import rsh_pkg::*;

  logic               en;
  logic               v1_q, v2_q, v3_q;
  logic signed [31:0] c_w [3];
  logic signed [31:0] o_w [3];
  logic signed [31:0] dir_w [3];
  logic signed [32:0] d_q [3];
  logic signed [31:0] v_q [3];
  logic        [30:0] rad_q;
  logic signed [65:0] dd_q [3];
  logic signed [64:0] dv_q [3];
  logic signed [63:0] vv_q [3];
  logic        [61:0] rr_q;
  logic signed [66:0] outside_d, outside_q;
  logic signed [65:0] proj_d, proj_q;
  logic signed [65:0] vsum;
  logic        [63:0] vl2_q;

  assign c_w   = '{center_x_i, center_y_i, center_z_i};
  assign o_w   = '{origin_x_i, origin_y_i, origin_z_i};
  assign dir_w = '{dir_x_i, dir_y_i, dir_z_i};

  assign en           = !v3_q || item_ready_i;
  assign in_ready_o   = en;
  assign item_valid_o = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign outside_d = 67'(dd_q[0]) + 67'(dd_q[1]) + 67'(dd_q[2]) - $signed({5'b0, rr_q});
  assign proj_d    = 66'(dv_q[0]) + 66'(dv_q[1]) + 66'(dv_q[2]);
  assign vsum      = 66'(vv_q[0]) + 66'(vv_q[1]) + 66'(vv_q[2]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d_q[k]  <= $signed({c_w[k][31], c_w[k]}) - $signed({o_w[k][31], o_w[k]});
        v_q[k]  <= dir_w[k];
        dd_q[k] <= d_q[k] * d_q[k];
        dv_q[k] <= d_q[k] * v_q[k];
        vv_q[k] <= v_q[k] * v_q[k];
      end
      rad_q     <= sphere_radius_i;
      rr_q      <= rad_q * rad_q;
      outside_q <= outside_d;
      proj_q    <= proj_d;
      vl2_q     <= vsum[63:0];
    end
  end

  // An origin inside or on the sphere is a hit at zero; otherwise a segment
  // heading away from the center can never reach it.
  always_comb begin
    item_o.origin_in = outside_q[66] || (outside_q == '0);
    item_o.miss      = !item_o.origin_in && (proj_q[65] || (proj_q == '0));
    item_o.proj      = proj_q[64:0];
    item_o.vl2       = vl2_q;
    item_o.outside   = outside_q[65:0];
  end

endmodule

// File: sv/rsh_fifo.sv
module rsh_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  rsh_pkg::rsh_item_t push_item_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output rsh_pkg::rsh_item_t pop_item_o
);
  import rsh_pkg::*;

  logic [FIFO_PTR_W-1:0] wr_q, rd_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  rsh_item_t             mem_q [FIFO_DEPTH];
  logic                  push, pop;

  assign push_ready_o = cnt_q != FIFO_CNT_W'(FIFO_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop) rd_q <= rd_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue count exceeds depth");

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> cnt_q == FIFO_CNT_W'($past(cnt_q) + 1'b1))
    else $error("queue count did not follow a lone write");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with unequal pointers");

endmodule

// File: sv/rsh_back.sv
module rsh_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  rsh_pkg::rsh_item_t item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic        [16:0] hit_fraction_o
);
  import rsh_pkg::*;

  typedef struct packed {
    logic        valid;
    logic        origin_in;
    logic        miss;
    logic [64:0] proj;
    logic [63:0] vl2;
    logic [65:0] ppll, pphl, pphh;
    logic [65:0] voll, volh, vohl, vohh;
  } prod_t;

  typedef struct packed {
    logic         valid;
    logic         origin_in;
    logic         miss;
    logic [64:0]  proj;
    logic [63:0]  vl2;
    logic [131:0] pp;
    logic [131:0] vo;
  } sum_t;

  typedef struct packed {
    logic         valid;
    logic         origin_in;
    logic         miss;
    logic [64:0]  proj;
    logic [63:0]  vl2;
    logic [129:0] rad;
    logic [67:0]  rem;
    logic [64:0]  root;
  } sq_t;

  typedef struct packed {
    logic        valid;
    logic        origin_in;
    logic        miss;
    logic [63:0] vl2;
    logic [64:0] rem;
    logic [16:0] quo;
  } dv_t;

  logic                en;
  logic                b0_valid_q;
  rsh_item_t           b0_q;
  prod_t               b1_q;
  sum_t                b2_q;
  sq_t                 sq_q [SQRT_STEPS+1];
  dv_t                 dv_q [DIV_STEPS+1];
  logic                out_valid_q, hit_q;
  logic         [16:0] frac_q;
  logic         [65:0] pa, va, oa;
  logic        [132:0] diff;
  logic         [64:0] num;
  logic                hit_nd;

  assign en             = !out_valid_q || out_ready_i;
  assign item_ready_o   = en;
  assign out_valid_o    = out_valid_q;
  assign hit_o          = hit_q;
  assign hit_fraction_o = frac_q;

  assign pa   = {1'b0, b0_q.proj};
  assign va   = {2'b0, b0_q.vl2};
  assign oa   = b0_q.outside;
  assign diff = {1'b0, b2_q.pp} - {1'b0, b2_q.vo};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_valid_q <= 1'b0;
      b0_q       <= '0;
      b1_q       <= '0;
      b2_q       <= '0;
      sq_q[0]    <= '0;
    end else if (en) begin
      b0_valid_q   <= item_valid_i;
      b0_q         <= item_i;
      // Wide square and product built from 33-bit halves.
      b1_q.valid     <= b0_valid_q;
      b1_q.origin_in <= b0_q.origin_in;
      b1_q.miss      <= b0_q.miss;
      b1_q.proj      <= b0_q.proj;
      b1_q.vl2       <= b0_q.vl2;
      b1_q.ppll      <= pa[32:0] * pa[32:0];
      b1_q.pphl      <= pa[65:33] * pa[32:0];
      b1_q.pphh      <= pa[65:33] * pa[65:33];
      b1_q.voll      <= va[32:0] * oa[32:0];
      b1_q.volh      <= va[32:0] * oa[65:33];
      b1_q.vohl      <= va[65:33] * oa[32:0];
      b1_q.vohh      <= va[65:33] * oa[65:33];
      b2_q.valid     <= b1_q.valid;
      b2_q.origin_in <= b1_q.origin_in;
      b2_q.miss      <= b1_q.miss;
      b2_q.proj      <= b1_q.proj;
      b2_q.vl2       <= b1_q.vl2;
      b2_q.pp        <= {b1_q.pphh, 66'b0} + 132'({b1_q.pphl, 34'b0}) + 132'(b1_q.ppll);
      b2_q.vo        <= {b1_q.vohh, 66'b0} + 132'({b1_q.volh, 33'b0})
                        + 132'({b1_q.vohl, 33'b0}) + 132'(b1_q.voll);
      // A negative discriminant means the line passes the sphere by.
      sq_q[0].valid     <= b2_q.valid;
      sq_q[0].origin_in <= b2_q.origin_in;
      sq_q[0].miss      <= b2_q.miss || diff[132];
      sq_q[0].proj      <= b2_q.proj;
      sq_q[0].vl2       <= b2_q.vl2;
      sq_q[0].rad       <= diff[129:0];
      sq_q[0].rem       <= '0;
      sq_q[0].root      <= '0;
    end
  end

  // Restoring square root: each stage brings down two radicand bits and
  // decides one root bit.
  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sq
    logic [67:0] rem_sh, trial;
    logic        ge;
    sq_t         nxt;

    assign rem_sh = {sq_q[i].rem[65:0], sq_q[i].rad[129:128]};
    assign trial  = {1'b0, sq_q[i].root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_comb begin
      nxt      = sq_q[i];
      nxt.rad  = {sq_q[i].rad[127:0], 2'b00};
      nxt.rem  = ge ? rem_sh - trial : rem_sh;
      nxt.root = {sq_q[i].root[63:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_q[i+1] <= '0;
      end else if (en) begin
        sq_q[i+1] <= nxt;
      end
    end
  end

  // The near root never exceeds the projection, so the numerator is
  // non-negative. A numerator of twice the squared direction length or more is a sure miss.
  assign num = sq_q[SQRT_STEPS].proj - sq_q[SQRT_STEPS].root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q[0] <= '0;
    end else if (en) begin
      dv_q[0].valid     <= sq_q[SQRT_STEPS].valid;
      dv_q[0].origin_in <= sq_q[SQRT_STEPS].origin_in;
      dv_q[0].miss      <= sq_q[SQRT_STEPS].miss || (num >= {sq_q[SQRT_STEPS].vl2, 1'b0});
      dv_q[0].vl2       <= sq_q[SQRT_STEPS].vl2;
      dv_q[0].rem       <= num;
      dv_q[0].quo       <= '0;
    end
  end

  // Restoring division, one quotient bit per stage; the first stage yields
  // the integer bit.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_dv
    logic [64:0] t;
    logic        ge;
    dv_t         nxt;

    if (i == 0) begin : g_first
      assign t = dv_q[i].rem;
    end else begin : g_rest
      assign t = {dv_q[i].rem[63:0], 1'b0};
    end
    assign ge = t >= {1'b0, dv_q[i].vl2};

    always_comb begin
      nxt     = dv_q[i];
      nxt.rem = ge ? t - {1'b0, dv_q[i].vl2} : t;
      nxt.quo = {dv_q[i].quo[15:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[i+1] <= '0;
      end else if (en) begin
        dv_q[i+1] <= nxt;
      end
    end
  end

  assign hit_nd = !dv_q[DIV_STEPS].miss && (dv_q[DIV_STEPS].quo <= FRAC_ONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      frac_q      <= FRAC_ZERO;
    end else if (en) begin
      out_valid_q <= dv_q[DIV_STEPS].valid;
      hit_q       <= dv_q[DIV_STEPS].origin_in || hit_nd;
      frac_q      <= (!dv_q[DIV_STEPS].origin_in && hit_nd) ? dv_q[DIV_STEPS].quo
                                                            : FRAC_ZERO;
    end
  end

endmodule

// File: sv/ray_sphere_hit_test.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   center, sphere_radius, origin, dir
// out      output     out_valid_o / out_ready_i hit, hit_fraction
//
// One test enters per cycle and one result leaves per cycle when neither side stalls.
// A test passes through 92 register stages once accepted (three front,
// one queue entry, three product and sum, one discriminant, 65 square-root, one numerator,
// 17 divide and the output register), the first loaded by the accepting edge.
// A stalled output holds the back pipeline; the front keeps running until the
// four-entry queue fills, then in_ready_o drops.
// Reset clears all valid bits and the queue; no result is pending after reset.
module ray_sphere_hit_test (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic        [30:0] sphere_radius_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               hit_o,
  output logic        [16:0] hit_fraction_o
);
  import rsh_pkg::*;

  logic      f_valid, f_ready, b_valid, b_ready;
  rsh_item_t f_item, b_item;

  rsh_front u_front (
    .center_x_i      (center_x_i),
    .center_y_i      (center_y_i),
    .center_z_i      (center_z_i),
    .sphere_radius_i (sphere_radius_i),
    .origin_x_i      (origin_x_i),
    .origin_y_i      (origin_y_i),
    .origin_z_i      (origin_z_i),
    .dir_x_i         (dir_x_i),
    .dir_y_i         (dir_y_i),
    .dir_z_i         (dir_z_i),
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .item_valid_o    (f_valid),
    .item_ready_i    (f_ready),
    .item_o          (f_item)
  );

  rsh_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .push_item_i  (f_item),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready),
    .pop_item_o   (b_item)
  );

  rsh_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (b_valid),
    .item_ready_o   (b_ready),
    .item_i         (b_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .hit_o          (hit_o),
    .hit_fraction_o (hit_fraction_o)
  );

endmodule

// File: sim/ray_sphere_hit_checker.sv
`timescale 1ns / 1ps

module ray_sphere_hit_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [31:0] center_x_i,
  input  logic signed [31:0] center_y_i,
  input  logic signed [31:0] center_z_i,
  input  logic        [30:0] sphere_radius_i,
  input  logic signed [31:0] origin_x_i,
  input  logic signed [31:0] origin_y_i,
  input  logic signed [31:0] origin_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               hit_i,
  input  logic        [16:0] hit_fraction_i,
  output int                 pending_o,
  output int                 errors_o
);

  typedef struct packed {
    logic        hit;
    logic [16:0] fraction;
  } hit_result_t;

  hit_result_t expected_hits[$];
  int          pending_cnt;
  int          error_cnt;

  assign pending_o = pending_cnt;
  assign errors_o  = error_cnt;

  // All products are taken at 192 bits, so every intermediate value is exact.
  function automatic hit_result_t predict_hit(
    input logic signed [31:0] cx, input logic signed [31:0] cy,
    input logic signed [31:0] cz, input logic [30:0] rad,
    input logic signed [31:0] ox, input logic signed [31:0] oy,
    input logic signed [31:0] oz, input logic signed [31:0] vx_in,
    input logic signed [31:0] vy_in, input logic signed [31:0] vz_in);
    logic signed [191:0] dx, dy, dz, vx, vy, vz, rr;
    logic signed [191:0] outside, proj, vl2, disc;
    logic        [191:0] root, cand, num, quo;
    hit_result_t         res;
    res = '0;
    dx = 192'(cx) - 192'(ox);
    dy = 192'(cy) - 192'(oy);
    dz = 192'(cz) - 192'(oz);
    vx = 192'(vx_in);
    vy = 192'(vy_in);
    vz = 192'(vz_in);
    rr = $signed({161'b0, rad});
    outside = dx * dx + dy * dy + dz * dz - rr * rr;
    if (outside <= 0) begin
      res.hit = 1'b1;
      return res;
    end
    proj = dx * vx + dy * vy + dz * vz;
    if (proj <= 0) return res;
    vl2  = vx * vx + vy * vy + vz * vz;
    disc = proj * proj - vl2 * outside;
    if (disc < 0) return res;
    root = '0;
    for (int b = 66; b >= 0; b--) begin
      cand = root | (192'd1 << b);
      if (cand * cand <= $unsigned(disc)) root = cand;
    end
    num = $unsigned(proj) - root;
    if (num >= (192'd1 << 64) || $unsigned(vl2) >= (192'd1 << 64) || vl2 == 0) return res;
    quo = (num << 16) / $unsigned(vl2);
    if (quo > 192'd65536) return res;
    res.hit      = 1'b1;
    res.fraction = quo[16:0];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    hit_result_t exp_res;
    if (!rst_ni) begin
      expected_hits.delete();
      pending_cnt = 0;
      error_cnt   = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        expected_hits.push_back(predict_hit(center_x_i, center_y_i, center_z_i,
          sphere_radius_i, origin_x_i, origin_y_i, origin_z_i, dir_x_i, dir_y_i, dir_z_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_hits.size() == 0) begin
          $error("unexpected result: hit=%0d hit_fraction=%0d", hit_i, hit_fraction_i);
          error_cnt++;
        end else begin
          exp_res = expected_hits.pop_front();
          if (hit_i !== exp_res.hit) begin
            $error("hit mismatch: expected %0d, actual %0d", exp_res.hit, hit_i);
            error_cnt++;
          end
          if (hit_fraction_i !== exp_res.fraction) begin
            $error("hit_fraction mismatch: expected %0d, actual %0d",
                   exp_res.fraction, hit_fraction_i);
            error_cnt++;
          end
        end
      end
      pending_cnt = expected_hits.size();
    end
  end

endmodule

// File: sim/ray_sphere_hit_test_test.sv
`timescale 1ns / 1ps

module ray_sphere_hit_test_test;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ONE         = 32'h0001_0000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] center_x_i = '0, center_y_i = '0, center_z_i = '0;
  logic        [30:0] sphere_radius_i = '0;
  logic signed [31:0] origin_x_i = '0, origin_y_i = '0, origin_z_i = '0;
  logic signed [31:0] dir_x_i = '0, dir_y_i = '0, dir_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic               hit_o;
  logic        [16:0] hit_fraction_o;
  int                 pending_cnt, error_cnt;
  int unsigned        send_idle_pct, recv_stall_pct;
  int unsigned        cycle_cnt = 0;

  ray_sphere_hit_test dut (.*);

  ray_sphere_hit_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .center_x_i, .center_y_i, .center_z_i, .sphere_radius_i,
    .origin_x_i, .origin_y_i, .origin_z_i, .dir_x_i, .dir_y_i, .dir_z_i,
    .out_valid_i(out_valid_o), .out_ready_i, .hit_i(hit_o), .hit_fraction_i(hit_fraction_o),
    .pending_o(pending_cnt), .errors_o(error_cnt)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Random gaps come first, then the transaction is held until accepted.
  task automatic send_test(input logic signed [31:0] cx, cy, cz, input logic [30:0] rad,
                           input logic signed [31:0] ox, oy, oz, vx, vy, vz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    center_x_i      <= cx;
    center_y_i      <= cy;
    center_z_i      <= cz;
    sphere_radius_i <= rad;
    origin_x_i      <= ox;
    origin_y_i      <= oy;
    origin_z_i      <= oz;
    dir_x_i         <= vx;
    dir_y_i         <= vy;
    dir_z_i         <= vz;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  function automatic logic signed [31:0] coord(input int unsigned span);
    return $signed($urandom_range(2 * span)) - $signed(span);
  endfunction

  // Mostly segments aimed near the sphere, so hits, tangents and short misses all occur.
  task automatic send_random_test();
    logic signed [31:0] cx, cy, cz, offx, offy, offz, jx, jy, jz;
    logic        [30:0] rad;
    int unsigned        mode, span;
    int                 scale;
    mode = $urandom_range(9);
    span = ($urandom_range(7) == 0) ? 32'h4000_0000 : 32'h0040_0000;
    if (mode == 0) begin
      send_test($urandom, $urandom, $urandom, 31'($urandom), $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
    end else begin
      cx   = coord(span);
      cy   = coord(span);
      cz   = coord(span);
      rad  = 31'($urandom_range(span / 4));
      offx = coord(span / 2);
      offy = coord(span / 2);
      offz = coord(span / 2);
      jx   = coord(span / 16);
      jy   = coord(span / 16);
      jz   = coord(span / 16);
      scale = $urandom_range(4, 1);
      if (mode == 1) begin
        send_test(cx, cy, cz, rad, cx + (offx >>> 3), cy, cz, jx, jy, jz);
      end else begin
        send_test(cx, cy, cz, rad, cx + offx, cy + offy, cz + offz,
                  -(offx >>> 1) * scale / 2 + jx, -(offy >>> 1) * scale / 2 + jy,
                  -(offz >>> 1) * scale / 2 + jz);
      end
    end
  endtask

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Origin on a zero-radius sphere, inside, exact far-end hit, just short of it.
    send_test(0, 0, 0, 31'd0, 0, 0, 0, 0, 0, 0);
    send_test(0, 0, 0, 31'(ONE), ONE / 2, 0, 0, ONE, 0, 0);
    send_test(0, 0, 0, 31'(ONE), -2 * ONE, 0, 0, ONE, 0, 0);
    send_test(0, 0, 0, 31'(ONE), -2 * ONE, 0, 0, ONE - 1, 0, 0);
    send_test(0, 0, 0, 31'(ONE), -2 * ONE, 0, 0, 2 * ONE, 0, 0);
    send_test(0, 0, 0, 31'(ONE), -2 * ONE, 0, 0, ONE / 2, 0, 0);
    // Tangent, just outside tangent, pointing away, zero direction.
    send_test(0, ONE, 0, 31'(ONE), -2 * ONE, 0, 0, 4 * ONE, 0, 0);
    send_test(0, ONE + 1, 0, 31'(ONE), -2 * ONE, 0, 0, 4 * ONE, 0, 0);
    send_test(0, 0, 0, 31'(ONE), -2 * ONE, 0, 0, -ONE, 0, 0);
    send_test(0, 0, 0, 31'(ONE), -2 * ONE, 0, 0, 0, 0, 0);
    // Field extremes.
    send_test(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_test(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'd0,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_test(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_test(32'h8000_0000, 0, 0, 31'd1, 32'h7fff_ffff, 0, 0, 32'h8000_0000, 0, 0);
    send_test(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff,
              0, 0, 0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_test(0, 0, 0, 31'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 1) ? 59 : 28) : 0;
      recv_stall_pct = (phase == 2 || phase == 3) ? ((phase == 2) ? 59 : 28) : 0;
      for (int n = 0; n < 375; n++) begin
        send_random_test();
      end
      if (phase == 0) begin
        // Hold off the sender until the pipeline has fully drained.
        in_valid_i <= 1'b0;
        while (pending_cnt != 0) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (error_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/rsh_pkg.sv
sv/rsh_front.sv
sv/rsh_fifo.sv
sv/rsh_back.sv
sv/ray_sphere_hit_test.sv
sim/ray_sphere_hit_checker.sv
sim/ray_sphere_hit_test_test.sv
